// File: rtl/bfpk_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register indexes and controller/datapath interface types.
package bfpk_pkg;

  localparam int unsigned CfgW    = 13;
  localparam int unsigned RowW    = 12;
  localparam int unsigned ColW    = 12;
  localparam int unsigned ElemW   = 16;
  localparam int unsigned AddrW   = 24;
  localparam int unsigned CfgIdxW = 2;

  localparam int unsigned PanelW  = 64;
  localparam int unsigned TailW   = 16;

  localparam logic [CfgIdxW-1:0] CFG_DEPTH = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_WIDTH = CfgIdxW'(1);

  typedef struct packed {
    logic load;
    logic issue;
    logic row_pad;
    logic col_cur;
    logic pad;
    logic last;
    logic col_adv;
  } dp_cmd_t;

  typedef struct packed {
    logic bad;
    logic pad_row;
    logic tail;
    logic col_last;
  } dp_status_t;

endpackage

// File: rtl/bfpk_dp.sv
`timescale 1ns / 1ps
// Datapath: size registers, request capture, packed address computation, result register.
module bfpk_dp #(
  parameter int unsigned MAX_DEPTH = 4096,
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bfpk_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bfpk_pkg::CfgW-1:0]     cfg_data_i,
  input  logic [bfpk_pkg::RowW-1:0]     row_index_i,
  input  logic [bfpk_pkg::ColW-1:0]     col_index_i,
  input  logic [bfpk_pkg::ElemW-1:0]    element_i,
  input  bfpk_pkg::dp_cmd_t             cmd_i,
  output bfpk_pkg::dp_status_t          status_o,
  output logic [bfpk_pkg::AddrW-1:0]    dest_address_o,
  output logic [bfpk_pkg::ElemW-1:0]    write_value_o,
  output logic                          is_padding_o,
  output logic                          bad_position_o,
  output logic                          last_write_o
);
  import bfpk_pkg::*;

  localparam int unsigned PB  = $clog2(PanelW);
  localparam int unsigned TB  = $clog2(TailW);
  localparam int unsigned WqW = PB - TB + 1;

  logic [CfgW-1:0]   depth_q, width_q;
  logic [CfgW-1:0]   kd, nw;
  logic [CfgW:0]     kp;

  logic [RowW-1:0]   row_q;
  logic [ColW-1:0]   col_q;
  logic [ElemW-1:0]  elem_q;
  logic              bad_q, pad_row_q, tail_q;
  logic [CfgW-1:0]   cur_q;

  logic [CfgW-1:0]   sel_row, sel_col, full, tail_start, cstart;
  logic [WqW-1:0]    wq;
  logic [PB-1:0]     lc;
  logic [2*CfgW:0]   base;
  logic [CfgW+WqW-2:0] row_prod;
  logic [AddrW-1:0]  addr;
  logic              is_bad;

  logic [AddrW-1:0]  dest_q;
  logic [ElemW-1:0]  value_q;
  logic              pad_q, badp_q, last_q;

  assign kd = (32'(depth_q) > 32'(MAX_DEPTH)) ? CfgW'(MAX_DEPTH) : depth_q;
  assign nw = (32'(width_q) > 32'(MAX_WIDTH)) ? CfgW'(MAX_WIDTH) : width_q;
  assign kp = {1'b0, kd} + (CfgW+1)'(kd[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= CfgW'(1);
      width_q <= CfgW'(1);
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_DEPTH) depth_q <= cfg_data_i;
      if (cfg_index_i == CFG_WIDTH) width_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      row_q     <= row_index_i;
      col_q     <= col_index_i;
      elem_q    <= element_i;
      bad_q     <= ({1'b0, row_index_i} >= kd) || ({1'b0, col_index_i} >= nw);
      pad_row_q <= kd[0] && ({1'b0, row_index_i} == kd - CfgW'(1));
      tail_q    <= (nw[TB-1:0] != '0) && ({1'b0, col_index_i} == nw - CfgW'(1));
      cur_q     <= nw;
    end else if (cmd_i.col_adv) begin
      cur_q <= cur_q + CfgW'(1);
    end
  end

  assign status_o.bad      = bad_q;
  assign status_o.pad_row  = pad_row_q;
  assign status_o.tail     = tail_q;
  assign status_o.col_last = (cur_q == (nw | CfgW'(TailW - 1)));

  assign sel_row    = cmd_i.row_pad ? kd : {1'b0, row_q};
  assign sel_col    = cmd_i.col_cur ? cur_q : {1'b0, col_q};
  assign full       = {nw[CfgW-1:PB], PB'(0)};
  assign tail_start = {nw[CfgW-1:TB], TB'(0)};

  always_comb begin
    if (sel_col < full) begin
      cstart = {sel_col[CfgW-1:PB], PB'(0)};
      wq     = WqW'(PanelW / TailW);
      lc     = sel_col[PB-1:0];
    end else if (sel_col < tail_start) begin
      cstart = full;
      wq     = WqW'(nw[PB-1:TB]);
      lc     = sel_col[PB-1:0];
    end else begin
      cstart = tail_start;
      wq     = WqW'(1);
      lc     = PB'(sel_col[TB-1:0]);
    end
  end

  assign base     = cstart * kp;
  assign row_prod = sel_row[CfgW-1:1] * wq;
  assign addr     = AddrW'(base) + AddrW'({row_prod, (TB+1)'(0)})
                  + AddrW'({lc, 1'b0}) + AddrW'(sel_row[0]);
  assign is_bad   = bad_q && !cmd_i.pad;

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      dest_q  <= is_bad ? '0 : addr;
      value_q <= (is_bad || cmd_i.pad) ? '0 : elem_q;
      pad_q   <= cmd_i.pad;
      badp_q  <= is_bad;
      last_q  <= cmd_i.last;
    end
  end

  assign dest_address_o = dest_q;
  assign write_value_o  = value_q;
  assign is_padding_o   = pad_q;
  assign bad_position_o = badp_q;
  assign last_write_o   = last_q;

endmodule

// File: rtl/bfpk_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences the element, row pad and tail column pad results of one request.
module bfpk_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  bfpk_pkg::dp_status_t  status_i,
  output bfpk_pkg::dp_cmd_t     cmd_o
);
  import bfpk_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ELEM   = 3'd1;
  localparam logic [2:0] S_ROWPAD = 3'd2;
  localparam logic [2:0] S_COLPAD = 3'd3;
  localparam logic [2:0] S_COLROW = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_ELEM;
        end
      end
      S_ELEM: begin
        cmd_o.last = status_i.bad || (!status_i.pad_row && !status_i.tail);
        if (slot_free) begin
          cmd_o.issue = 1'b1;
          if (status_i.bad)          state_d = S_IDLE;
          else if (status_i.pad_row) state_d = S_ROWPAD;
          else if (status_i.tail)    state_d = S_COLPAD;
          else                       state_d = S_IDLE;
        end
      end
      S_ROWPAD: begin
        cmd_o.row_pad = 1'b1;
        cmd_o.pad     = 1'b1;
        cmd_o.last    = !status_i.tail;
        if (slot_free) begin
          cmd_o.issue = 1'b1;
          state_d     = status_i.tail ? S_COLPAD : S_IDLE;
        end
      end
      S_COLPAD: begin
        cmd_o.col_cur = 1'b1;
        cmd_o.pad     = 1'b1;
        cmd_o.last    = !status_i.pad_row && status_i.col_last;
        if (slot_free) begin
          cmd_o.issue = 1'b1;
          if (status_i.pad_row) begin
            state_d = S_COLROW;
          end else if (status_i.col_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.col_adv = 1'b1;
          end
        end
      end
      S_COLROW: begin
        cmd_o.col_cur = 1'b1;
        cmd_o.row_pad = 1'b1;
        cmd_o.pad     = 1'b1;
        cmd_o.last    = status_i.col_last;
        if (slot_free) begin
          cmd_o.issue = 1'b1;
          if (status_i.col_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.col_adv = 1'b1;
            state_d       = S_COLPAD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.issue)      out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else                  out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/bf16_pair_interleave_packer_core.sv
`timescale 1ns / 1ps
// Top level: pair-interleaved packed-buffer address generator for 16-bit matrix elements.
//
// Input channel (in_valid_i/in_ready_o) takes one request: an element with its row and
// column. Output channel (out_valid_o/out_ready_i) returns write results: the element
// at its packed offset, then any zero pad writes it triggers (the pad row of an odd
// depth and the pad columns of the 16-wide tail panel). last_write_o marks the final
// result of a request. A position outside the configured size yields one result with
// bad_position_o set and nothing to write.
// Config channel (cfg_valid_i/cfg_ready_o) writes depth_rows (index 0) or width_cols
// (index 1); it is always ready and is meant to be used while the block is idle.
// Timing: acceptance captures the request and moves the controller to its element state,
// from which the first result is registered on the output. A request producing R results
// (1 to 32) occupies the controller until its last result is issued, one result issued
// per cycle by the sequencer while the output is free. A single result register sits on
// the output; under a receiver stall the sequencer holds until the result is taken.
// Reset: depth and width return to 1, the controller goes idle, no result is pending.
module bf16_pair_interleave_packer_core #(
  parameter int unsigned MAX_DEPTH = 4096,
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bfpk_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bfpk_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bfpk_pkg::RowW-1:0]     row_index_i,
  input  logic [bfpk_pkg::ColW-1:0]     col_index_i,
  input  logic [bfpk_pkg::ElemW-1:0]    element_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bfpk_pkg::AddrW-1:0]    dest_address_o,
  output logic [bfpk_pkg::ElemW-1:0]    write_value_o,
  output logic                          is_padding_o,
  output logic                          bad_position_o,
  output logic                          last_write_o
);
  import bfpk_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  bfpk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bfpk_dp #(
    .MAX_DEPTH (MAX_DEPTH),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .element_i      (element_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .dest_address_o (dest_address_o),
    .write_value_o  (write_value_o),
    .is_padding_o   (is_padding_o),
    .bad_position_o (bad_position_o),
    .last_write_o   (last_write_o)
  );

  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_position_o |-> last_write_o && !is_padding_o && dest_address_o == '0)
    else $error("bad position result not a lone zero result");

  a_pad_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_padding_o |-> write_value_o == '0 && !bad_position_o)
    else $error("pad write carries nonzero value");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while previous one still sequencing");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(dest_address_o)
      && $stable(last_write_o))
    else $error("result changed under stall");

endmodule
